// ----- hdl/ssfa_pkg.sv -----
package ssfa_pkg;

    // Configuration registers as written through the register port.
    typedef struct packed {
        logic [12:0] tex_width;
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic [12:0] src_w;
        logic [12:0] src_h;
        logic [8:0]  frame_count;
        logic [14:0] frame_delay;
    } t_cfg;

    // Register indexes, byte address is four times the index.
    localparam logic [2:0] REG_TEX_WIDTH   = 3'd0;
    localparam logic [2:0] REG_SRC_X       = 3'd1;
    localparam logic [2:0] REG_SRC_Y       = 3'd2;
    localparam logic [2:0] REG_SRC_W       = 3'd3;
    localparam logic [2:0] REG_SRC_H       = 3'd4;
    localparam logic [2:0] REG_FRAME_COUNT = 3'd5;
    localparam logic [2:0] REG_FRAME_DELAY = 3'd6;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Largest values the count and width registers can hold.
    localparam int FRAME_COUNT_LIMIT = 511;
    localparam int TEX_WIDTH_LIMIT   = 8191;

    localparam logic [14:0] TICK_STEP = 15'd16;
    localparam logic [14:0] DELAY_MIN = 15'd16;
    localparam logic [14:0] DELAY_MAX = 15'd32736;

    localparam int V_W = 33;

endpackage

// ----- hdl/ssfa_fifo.sv -----
module ssfa_fifo #(
    parameter int DATA_W = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    // Two-entry queue; the writer never pushes when full, the reader never pops when empty.
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

// ----- hdl/ssfa_front.sv -----
module ssfa_front
    import ssfa_pkg::*;
#(
    parameter int CNT_MAX = 256,
    parameter int CNT_W   = 9,
    parameter int CUR_W   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_req_type,
    input  logic [7:0]       i_frame_index,
    input  logic             i_q_full,
    output logic             o_q_push,
    output logic             o_q_accepted,
    output logic [CUR_W-1:0] o_q_frame
);

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    logic [14:0]      r_accum;
    logic [14:0]      n_accum;
    logic [CUR_W-1:0] r_cur;
    logic [CUR_W-1:0] n_cur;
    logic [CNT_W-1:0] w_count;
    logic [14:0]      w_delay;
    logic [14:0]      w_acc_sum;
    logic [CUR_W:0]   w_next;
    logic [CUR_W:0]   w_wrap;
    logic             w_take;
    logic             w_ok;

    always_comb begin
        priority if (i_cfg.frame_count == 9'd0) begin
            w_count = CNT_W'(1);
        end else if (i_cfg.frame_count > 9'(CNT_MAX)) begin
            w_count = CNT_W'(CNT_MAX);
        end else begin
            w_count = CNT_W'(i_cfg.frame_count);
        end

        priority if (i_cfg.frame_delay < DELAY_MIN) begin
            w_delay = DELAY_MIN;
        end else if (i_cfg.frame_delay > DELAY_MAX) begin
            w_delay = DELAY_MAX;
        end else begin
            w_delay = i_cfg.frame_delay;
        end

        // The accumulator wraps at its 15-bit width.
        w_acc_sum = r_accum + TICK_STEP;
        w_next    = (CUR_W+1)'(r_cur) + (CUR_W+1)'(1);
        if (w_next >= w_count) begin
            w_wrap = w_next - (CUR_W+1)'(w_count);
        end else begin
            w_wrap = w_next;
        end

        n_accum = r_accum;
        n_cur   = r_cur;
        w_ok    = 1'b1;
        unique case (i_req_type)
            REQ_SET: begin
                if (i_frame_index < w_count) begin
                    n_cur = CUR_W'(i_frame_index);
                end else begin
                    w_ok = 1'b0;
                end
            end
            REQ_TICK: begin
                // A single-frame animation leaves even the accumulator alone.
                if (w_count > CNT_W'(1)) begin
                    n_accum = w_acc_sum;
                    if (w_acc_sum >= w_delay) begin
                        n_accum = w_acc_sum - w_delay;
                        n_cur   = CUR_W'(w_wrap);
                    end
                end
            end
            default: begin
                n_cur = r_cur;
            end
        endcase
    end

    assign w_take = i_valid & ~i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_cur   <= '0;
        end else if (w_take) begin
            r_accum <= n_accum;
            r_cur   <= n_cur;
        end
    end

    assign o_ready      = ~i_q_full;
    assign o_q_push     = w_take;
    assign o_q_accepted = w_ok;
    assign o_q_frame    = n_cur;

endmodule

// ----- hdl/ssfa_div.sv -----
module ssfa_div #(
    parameter int X_W  = 21,
    parameter int TW_W = 13
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [X_W-1:0]  i_dividend,
    input  logic [TW_W-1:0] i_divisor,
    output logic            o_done,
    output logic [X_W-1:0]  o_quotient,
    output logic [TW_W-1:0] o_remainder
);

    // Restoring division, one quotient bit per cycle.
    localparam int CNT_W = $clog2(X_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [X_W-1:0]   r_quo;
    logic [TW_W-1:0]  r_rem;
    logic [TW_W-1:0]  r_dvs;
    logic [TW_W:0]    w_shift;
    logic [TW_W:0]    w_diff;
    logic             w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[X_W-1]};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(X_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[X_W-2:0], w_ge};
            r_rem <= w_ge ? TW_W'(w_diff) : TW_W'(w_shift);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- hdl/ssfa_back.sv -----
module ssfa_back
    import ssfa_pkg::*;
#(
    parameter int CUR_W  = 8,
    parameter int X_W    = 21,
    parameter int TW_W   = 13,
    parameter int TW_MAX = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_q_accepted,
    input  logic [CUR_W-1:0] i_q_frame,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_accepted,
    output logic [7:0]       o_frame,
    output logic [11:0]      o_u_min,
    output logic [12:0]      o_u_max,
    output logic [V_W-1:0]   o_v_min,
    output logic [V_W-1:0]   o_v_max
);

    localparam int PROD_W = 13 + X_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic              r_acc;
    logic [CUR_W-1:0]  r_frame;
    logic [PROD_W-1:0] r_prod;
    logic [V_W-1:0]    r_y;
    logic              r_o_valid;
    logic              r_o_accepted;
    logic [7:0]        r_o_frame;
    logic [11:0]       r_o_u_min;
    logic [12:0]       r_o_u_max;
    logic [V_W-1:0]    r_o_v_min;
    logic [V_W-1:0]    r_o_v_max;

    logic [TW_W-1:0]   w_tw;
    logic [X_W-1:0]    w_x;
    logic              w_out_free;
    logic              w_div_start;
    logic              w_div_done;
    logic [X_W-1:0]    w_quo;
    logic [TW_W-1:0]   w_rem;

    always_comb begin
        priority if (i_cfg.tex_width == 13'd0) begin
            w_tw = TW_W'(1);
        end else if (i_cfg.tex_width > 13'(TW_MAX)) begin
            w_tw = TW_W'(TW_MAX);
        end else begin
            w_tw = TW_W'(i_cfg.tex_width);
        end
        w_x = X_W'(i_cfg.src_x) + X_W'(i_cfg.src_w) * X_W'(r_frame);
    end

    assign w_out_free  = ~r_o_valid | i_ready;
    assign o_q_pop     = (r_state == ST_IDLE) & ~i_q_empty;
    assign w_div_start = (r_state == ST_MUL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_MUL2;
            ST_MUL2: n_state = ST_ADD;
            ST_ADD:  n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    ssfa_div #(
        .X_W  (X_W),
        .TW_W (TW_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_x),
        .i_divisor   (w_tw),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_acc   <= i_q_accepted;
            r_frame <= i_q_frame;
        end
        if (r_state == ST_MUL2) begin
            r_prod <= PROD_W'(i_cfg.src_h) * PROD_W'(w_quo);
        end
        if (r_state == ST_ADD) begin
            r_y <= V_W'(r_prod) + V_W'(i_cfg.src_y);
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_o_accepted <= r_acc;
            r_o_frame    <= 8'(r_frame);
            r_o_u_min    <= 12'(w_rem);
            r_o_u_max    <= 13'(14'(w_rem) + 14'(i_cfg.src_w));
            r_o_v_min    <= r_y;
            r_o_v_max    <= V_W'(r_y + V_W'(i_cfg.src_h));
        end
    end

    assign o_valid    = r_o_valid;
    assign o_accepted = r_o_accepted;
    assign o_frame    = r_o_frame;
    assign o_u_min    = r_o_u_min;
    assign o_u_max    = r_o_u_max;
    assign o_v_min    = r_o_v_min;
    assign o_v_max    = r_o_v_max;

endmodule

// ----- hdl/sprite_sheet_frame_animator_unit.sv -----
// Sprite sheet frame animator. Each input transaction is either a display tick or a set-frame
// request; each one yields exactly one output transaction with the current frame index, a flag
// that is low only for an out-of-range set-frame, and the frame's texel rectangle in the sheet.
// Both channels use valid/ready. The front end updates the tick accumulator and frame index in
// the cycle a transaction is accepted and hands the frame to a two-entry queue; the back end
// turns it into a rectangle with a multiply, an iterative divide by the sheet width, a second
// multiply for the row offset and two adds.
// The divider resolves one quotient bit per cycle, which sets the pace: it works through
// X_W quotient bits per item, where X_W is the width of the horizontal offset (21 bits
// with the default parameters). The front end keeps accepting while the queue has room,
// so up to two items can wait behind the one being computed.
// When the receiver stalls, the finished result sits in the output register and the back end
// holds its next result until that register frees up; the queue then fills and input ready
// drops. Reset (synchronous, active low) clears the accumulator and frame index, empties the
// queue and the output, and loads the register defaults. Registers are written over the APB
// port at byte address 4 * index and should only change while the block is idle.
module sprite_sheet_frame_animator_unit
    import ssfa_pkg::*;
#(
    parameter int MAX_FRAMES = 256,
    parameter int TEX_SIZE   = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Item input channel.
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_req_type,
    input  logic [7:0]            i_frame_index,
    // Result output channel.
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_accepted,
    output logic [7:0]            o_frame,
    output logic [11:0]           o_u_min,
    output logic [12:0]           o_u_max,
    output logic [V_W-1:0]        o_v_min,
    output logic [V_W-1:0]        o_v_max,
    // Register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // The effective frame count is clamped by the parameter and by the register width.
    localparam int CNT_MAX = (MAX_FRAMES < FRAME_COUNT_LIMIT) ? MAX_FRAMES : FRAME_COUNT_LIMIT;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int CUR_W   = $clog2(CNT_MAX);
    // Largest horizontal offset before wrapping: src_x + src_w * frame.
    localparam int X_MAX   = 4095 + TEX_WIDTH_LIMIT * (CNT_MAX - 1);
    localparam int X_W     = $clog2(X_MAX + 1);
    localparam int TW_MAX  = (TEX_SIZE < TEX_WIDTH_LIMIT) ? TEX_SIZE : TEX_WIDTH_LIMIT;
    localparam int TW_W    = $clog2(TW_MAX + 1);

    t_cfg             r_cfg;
    logic [2:0]       w_reg_idx;
    logic             w_cfg_wr;

    logic             w_q_push;
    logic             w_q_pop;
    logic             w_q_full;
    logic             w_q_empty;
    logic             w_push_acc;
    logic [CUR_W-1:0] w_push_frame;
    logic [CUR_W:0]   w_q_out;

    // Register file. A write lands on the access cycle; addresses past the list are ignored.
    assign w_reg_idx = paddr[APB_ADDR_W-1:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_width   <= 13'd256;
            r_cfg.src_x       <= 12'd0;
            r_cfg.src_y       <= 12'd0;
            r_cfg.src_w       <= 13'd16;
            r_cfg.src_h       <= 13'd16;
            r_cfg.frame_count <= 9'd1;
            r_cfg.frame_delay <= 15'd16;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_TEX_WIDTH:   r_cfg.tex_width   <= pwdata[12:0];
                REG_SRC_X:       r_cfg.src_x       <= pwdata[11:0];
                REG_SRC_Y:       r_cfg.src_y       <= pwdata[11:0];
                REG_SRC_W:       r_cfg.src_w       <= pwdata[12:0];
                REG_SRC_H:       r_cfg.src_h       <= pwdata[12:0];
                REG_FRAME_COUNT: r_cfg.frame_count <= pwdata[8:0];
                REG_FRAME_DELAY: r_cfg.frame_delay <= pwdata[14:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_TEX_WIDTH:   prdata = APB_DATA_W'(r_cfg.tex_width);
            REG_SRC_X:       prdata = APB_DATA_W'(r_cfg.src_x);
            REG_SRC_Y:       prdata = APB_DATA_W'(r_cfg.src_y);
            REG_SRC_W:       prdata = APB_DATA_W'(r_cfg.src_w);
            REG_SRC_H:       prdata = APB_DATA_W'(r_cfg.src_h);
            REG_FRAME_COUNT: prdata = APB_DATA_W'(r_cfg.frame_count);
            REG_FRAME_DELAY: prdata = APB_DATA_W'(r_cfg.frame_delay);
            default:         prdata = '0;
        endcase
    end

    // Front end: animation state and request classification.
    ssfa_front #(
        .CNT_MAX (CNT_MAX),
        .CNT_W   (CNT_W),
        .CUR_W   (CUR_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_frame_index (i_frame_index),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_accepted  (w_push_acc),
        .o_q_frame     (w_push_frame)
    );

    // Queue between the two halves carries the accept flag and the resulting frame.
    ssfa_fifo #(
        .DATA_W (CUR_W + 1)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  ({w_push_acc, w_push_frame}),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // Back end: rectangle computation and the output register.
    ssfa_back #(
        .CUR_W  (CUR_W),
        .X_W    (X_W),
        .TW_W   (TW_W),
        .TW_MAX (TW_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_empty    (w_q_empty),
        .o_q_pop      (w_q_pop),
        .i_q_accepted (w_q_out[CUR_W]),
        .i_q_frame    (w_q_out[CUR_W-1:0]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_accepted   (o_accepted),
        .o_frame      (o_frame),
        .o_u_min      (o_u_min),
        .o_u_max      (o_u_max),
        .o_v_min      (o_v_min),
        .o_v_max      (o_v_max)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the sprite sheet frame animator.
//
// The stimulus is built up front by the main initial block in phases. Each phase first
// programs the seven sheet registers over the register port while the block is idle, and
// then queues a run of tick and set-frame requests. A clocked driver feeds the input
// channel from that queue, and a clocked monitor drains the output channel.
//
// Every accepted input transaction is run through a behavioral copy of the animator right
// at the accepting edge. The copy keeps its own accumulator, frame index and register
// shadow, and it pushes the frame rectangle it expects onto a FIFO. The monitor compares
// each output transaction against the oldest entry of that FIFO, field by field.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssfa_pkg::*;

    // These match the parameter defaults of the unit, which is built without overrides.
    localparam int MAX_FRAMES = 256;
    localparam int TEX_SIZE   = 4096;

    // Request kinds on the input channel.
    localparam logic REQ_TICK      = 1'b0;
    localparam logic REQ_SET_FRAME = 1'b1;

    // The limits below leave a wide margin over the back end's work on each item, for
    // receiver stalls and for the register writes between phases.
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RAND_PHASES   = 16;
    localparam int CALM_PHASE    = 5;
    localparam int IDLE_PCT      = 24;

    typedef struct packed {
        logic       kind;
        logic [7:0] index;
    } t_sprite_req;

    typedef struct packed {
        logic          accepted;
        logic [7:0]    frame;
        logic [11:0]   u_min;
        logic [12:0]   u_max;
        logic [V_W-1:0] v_min;
        logic [V_W-1:0] v_max;
    } t_frame_rect;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic                  i_req_type    = REQ_TICK;
    logic [7:0]            i_frame_index = 8'd0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic                  o_accepted;
    logic [7:0]            o_frame;
    logic [11:0]           o_u_min;
    logic [12:0]           o_u_max;
    logic [V_W-1:0]        o_v_min;
    logic [V_W-1:0]        o_v_max;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the sheet registers and of the animation state inside the unit.
    t_cfg        anim_cfg;
    logic [14:0] accum_q = '0;
    logic [7:0]  frame_q = '0;

    t_sprite_req req_backlog[$];
    t_frame_rect rect_expected[$];

    int  fail_count   = 0;
    int  quiet_cycles = 0;
    bit  calm_mode    = 1'b0;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Applies one request to the shadow state and returns the rectangle the unit must report.
    function automatic t_frame_rect advance_sprite(input logic kind, input logic [7:0] idx);
        int unsigned     count;
        int unsigned     delay;
        int unsigned     next_frame;
        longint unsigned sheet_w;
        longint unsigned col;
        longint unsigned top;
        longint unsigned row;
        t_frame_rect     r;

        count      = clamp_to(anim_cfg.frame_count, 1, MAX_FRAMES);
        r.accepted = 1'b1;
        if (kind == REQ_TICK) begin
            // With a single frame a tick leaves even the accumulator alone.
            if (count > 1) begin
                delay   = clamp_to(anim_cfg.frame_delay, DELAY_MIN, DELAY_MAX);
                accum_q = accum_q + TICK_STEP;
                if (accum_q >= delay) begin
                    // Only one delay and one frame count come off per tick, so stale
                    // values left by a reconfiguration drain over several ticks.
                    accum_q    = accum_q - delay[14:0];
                    next_frame = frame_q + 1;
                    if (next_frame >= count) next_frame = next_frame - count;
                    frame_q = next_frame[7:0];
                end
            end
        end else begin
            if (idx < count) frame_q = idx;
            else r.accepted = 1'b0;
        end

        sheet_w = clamp_to(anim_cfg.tex_width, 1, TEX_SIZE);
        col     = 64'(anim_cfg.src_x) + 64'(anim_cfg.src_w) * 64'(frame_q);
        row     = col / sheet_w;
        top     = 64'(anim_cfg.src_y);
        if (row > 0) begin
            col = col % sheet_w;
            top = 64'(anim_cfg.src_y) + 64'(anim_cfg.src_h) * row;
        end

        r.frame = frame_q;
        r.u_min = col[11:0];
        r.u_max = 13'(col + 64'(anim_cfg.src_w));
        r.v_min = top[V_W-1:0];
        r.v_max = V_W'(top + 64'(anim_cfg.src_h));
        return r;
    endfunction

    function automatic t_cfg make_sheet(input int unsigned tw, input int unsigned x,
                                        input int unsigned y, input int unsigned w,
                                        input int unsigned h, input int unsigned cnt,
                                        input int unsigned dly);
        t_cfg c;
        c.tex_width   = tw[12:0];
        c.src_x       = x[11:0];
        c.src_y       = y[11:0];
        c.src_w       = w[12:0];
        c.src_h       = h[12:0];
        c.frame_count = cnt[8:0];
        c.frame_delay = dly[14:0];
        return c;
    endfunction

    // Random sheet layout, leaning on the extremes and on small counts and delays so that
    // frames actually wrap and advance during a phase.
    function automatic t_cfg random_sheet();
        int unsigned tw, x, y, w, h, cnt, dly;

        case ($urandom_range(5))
            0:       tw = $urandom_range(1);
            1:       tw = $urandom_range(4096, 8191);
            2:       tw = 4096;
            3:       tw = $urandom_range(1, 64);
            default: tw = $urandom_range(1, 4096);
        endcase
        case ($urandom_range(3))
            0:       x = 0;
            1:       x = 4095;
            default: x = $urandom_range(4095);
        endcase
        case ($urandom_range(3))
            0:       y = 0;
            1:       y = 4095;
            default: y = $urandom_range(4095);
        endcase
        case ($urandom_range(4))
            0:       w = $urandom_range(1);
            1:       w = 8191;
            2:       w = $urandom_range(1, 64);
            default: w = $urandom_range(8191);
        endcase
        case ($urandom_range(4))
            0:       h = $urandom_range(1);
            1:       h = 8191;
            2:       h = $urandom_range(1, 64);
            default: h = $urandom_range(8191);
        endcase
        case ($urandom_range(5))
            0:       cnt = $urandom_range(1);
            1:       cnt = $urandom_range(256, 511);
            2:       cnt = 256;
            3:       cnt = $urandom_range(2, 8);
            default: cnt = $urandom_range(2, 255);
        endcase
        case ($urandom_range(4))
            0:       dly = $urandom_range(16);
            1:       dly = $urandom_range(32736, 32767);
            2:       dly = $urandom_range(16, 80);
            default: dly = $urandom_range(16, 400);
        endcase
        return make_sheet(tw, x, y, w, h, cnt, dly);
    endfunction

    // One register write: a setup cycle, then an access cycle. The register takes the
    // value at the edge that ends the access cycle, and the shadow follows right after.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TEX_WIDTH:   anim_cfg.tex_width   = value[12:0];
            REG_SRC_X:       anim_cfg.src_x       = value[11:0];
            REG_SRC_Y:       anim_cfg.src_y       = value[11:0];
            REG_SRC_W:       anim_cfg.src_w       = value[12:0];
            REG_SRC_H:       anim_cfg.src_h       = value[12:0];
            REG_FRAME_COUNT: anim_cfg.frame_count = value[8:0];
            REG_FRAME_DELAY: anim_cfg.frame_delay = value[14:0];
            default: ;
        endcase
    endtask

    // Writes all seven registers. With junk set, the unused upper bits of each write carry
    // random data, which the unit must drop.
    task automatic program_sheet(input t_cfg c, input bit junk);
        logic [31:0] fill;

        fill = junk ? $urandom : 32'd0;
        write_reg(REG_TEX_WIDTH,   {fill[31:13], c.tex_width});
        write_reg(REG_SRC_X,       {fill[31:12], c.src_x});
        write_reg(REG_SRC_Y,       {fill[30:11], c.src_y});
        write_reg(REG_SRC_W,       {fill[30:12], c.src_w});
        write_reg(REG_SRC_H,       {fill[29:11], c.src_h});
        write_reg(REG_FRAME_COUNT, {fill[31:9],  c.frame_count});
        write_reg(REG_FRAME_DELAY, {fill[31:15], c.frame_delay});
    endtask

    task automatic queue_req(input logic kind, input logic [7:0] idx);
        t_sprite_req rq;

        rq.kind  = kind;
        rq.index = idx;
        req_backlog.push_back(rq);
    endtask

    // Returns once every queued request has gone in and every result has come back. Every
    // request yields a result, so the unit is idle at that point and registers may change.
    task automatic wait_drained();
        while (req_backlog.size() != 0 || i_valid || rect_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    sprite_sheet_frame_animator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_frame_index (i_frame_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_accepted    (o_accepted),
        .o_frame       (o_frame),
        .o_u_min       (o_u_min),
        .o_u_max       (o_u_max),
        .o_v_min       (o_v_min),
        .o_v_max       (o_v_max),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Input driver. The values of i_valid and o_ready read here are the ones from before
    // the edge, so a transaction counts exactly when the unit sees it. The accepted request
    // is predicted on the spot, which keeps the shadow state in step with the unit. A new
    // request is only offered once the previous one is gone, so valid never drops early.
    always @(posedge i_clk) begin
        t_sprite_req rq;

        if (i_rst_n) begin
            if (i_valid && o_ready)
                rect_expected.push_back(advance_sprite(i_req_type, i_frame_index));
            if (!i_valid || o_ready) begin
                if (req_backlog.size() != 0 &&
                    (calm_mode || $urandom_range(99) >= IDLE_PCT)) begin
                    rq = req_backlog.pop_front();
                    i_valid       <= 1'b1;
                    i_req_type    <= rq.kind;
                    i_frame_index <= rq.index;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each output transaction must match the oldest prediction; ready is
    // dropped at random so that the back end stalls while it holds a finished result.
    always @(posedge i_clk) begin
        t_frame_rect want;

        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (rect_expected.size() == 0) begin
                    $error("unexpected result transaction: frame %0d", o_frame);
                    fail_count++;
                end else begin
                    want = rect_expected.pop_front();
                    check_field("accepted", want.accepted, o_accepted);
                    check_field("frame",    want.frame,    o_frame);
                    check_field("u_min",    want.u_min,    o_u_min);
                    check_field("u_max",    want.u_max,    o_u_max);
                    check_field("v_min",    want.v_min,    o_v_min);
                    check_field("v_max",    want.v_max,    o_v_max);
                end
            end
            i_ready <= calm_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: counts cycles in which no transaction of any kind completes.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pwrite))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int eff_count;
        int n_items;

        // Shadow of the register defaults that reset loads.
        anim_cfg = make_sheet(256, 0, 0, 16, 16, 1, 16);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: one frame only, so a tick changes nothing, frame zero can be
        // selected and any other index is turned away.
        queue_req(REQ_TICK,      8'd0);
        queue_req(REQ_SET_FRAME, 8'd0);
        queue_req(REQ_SET_FRAME, 8'd1);
        queue_req(REQ_SET_FRAME, 8'd255);
        wait_drained();

        // Narrow sheet, full frame count, one frame per tick. Frame zero fits in the first
        // row, frame two lands exactly on the sheet edge, and ticking from the last frame
        // wraps back to the first.
        program_sheet(make_sheet(64, 40, 4095, 12, 4096, 256, 16), 1'b0);
        queue_req(REQ_SET_FRAME, 8'd0);
        queue_req(REQ_SET_FRAME, 8'd2);
        queue_req(REQ_SET_FRAME, 8'd255);
        queue_req(REQ_TICK,      8'hff);
        queue_req(REQ_TICK,      8'h00);
        queue_req(REQ_SET_FRAME, 8'd170);
        queue_req(REQ_SET_FRAME, 8'd85);
        wait_drained();

        // Registers beyond their legal ranges: a zero sheet width acts as one texel, the
        // count and delay clamp at their tops, and the largest frame size pushes the rows
        // past 33 bits so that the top edge wraps.
        program_sheet(make_sheet(0, 4095, 4095, 8191, 8191, 511, 32767), 1'b0);
        queue_req(REQ_SET_FRAME, 8'd255);
        queue_req(REQ_TICK,      8'd0);
        queue_req(REQ_SET_FRAME, 8'd128);
        queue_req(REQ_TICK,      8'd0);
        wait_drained();

        // Zero count and delay clamp to one frame and the smallest delay; the frame left
        // over from the last phase stays put and every set-frame but zero is refused.
        program_sheet(make_sheet(8191, 0, 0, 1, 1, 0, 0), 1'b0);
        queue_req(REQ_TICK,      8'd0);
        queue_req(REQ_SET_FRAME, 8'd1);
        queue_req(REQ_SET_FRAME, 8'd200);
        wait_drained();

        // Three frames while the current one is still far above that: each advance takes
        // the count off only once, so the frame drains over several ticks.
        program_sheet(make_sheet(4096, 100, 7, 33, 9, 3, 48), 1'b0);
        repeat (5) queue_req(REQ_TICK, 8'd0);
        queue_req(REQ_SET_FRAME, 8'd2);
        wait_drained();

        // Random phases. The state carries over from phase to phase, so the accumulator and
        // the frame are often left above the new limits. One phase runs without any idling.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            program_sheet(random_sheet(), 1'b1);
            calm_mode = (ph == CALM_PHASE);
            eff_count = clamp_to(anim_cfg.frame_count, 1, MAX_FRAMES);
            n_items   = $urandom_range(95, 135);
            repeat (n_items) begin
                if ($urandom_range(99) < 70)
                    queue_req(REQ_TICK, 8'($urandom));
                else if ($urandom_range(3) != 0)
                    queue_req(REQ_SET_FRAME, 8'($urandom_range(eff_count - 1)));
                else
                    queue_req(REQ_SET_FRAME, 8'($urandom));
            end
            wait_drained();
        end
        calm_mode = 1'b0;

        // Leave time for any stray result to show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (rect_expected.size() != 0) fail_count++;
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
